>>> hdl/direct_mapped_icache_refill_top_macros.svh
// ----------------------------------------------------------------------------
// Instruction cache refill - assertion macros
// Shared assertion wrappers; they expand to nothing in a synthesis build.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_ICACHE_REFILL_TOP_MACROS_SVH
`define DIRECT_MAPPED_ICACHE_REFILL_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define DMIC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("icache assertion failed");
// Next-cycle implication, disabled during reset
`define DMIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("icache assertion failed");
`else
`define DMIC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define DMIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/dmicr_pkg.sv
// ----------------------------------------------------------------------------
// Instruction cache refill - package
// Fixed field widths and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package dmicr_pkg;

    // fixed field widths
    localparam int ADDR_W     = 25;
    localparam int TAG_W      = 16;
    localparam int DATA_W     = 32;
    localparam int HALF_W     = 64;
    localparam int OUT_W      = 2 * HALF_W;
    // beat index wide enough for the largest beat count (64 single-byte beats)
    localparam int MAX_BEAT_W = 6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                  capture;    // latch the request, start line read
        logic                  exec;       // lookup/update tick
        logic                  wr_en;      // write the beat into the line
        logic [MAX_BEAT_W-1:0] beat;       // beat slot being written
        logic                  clr_valid;  // first beat: drop the line
        logic                  set_valid;  // last beat: tag and validate the line
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic req;
        logic beat_valid;
        logic hit;
    } t_sts;

endpackage

>>> hdl/direct_mapped_icache_refill_top.sv
// ----------------------------------------------------------------------------
// Instruction cache refill - top level
// Direct-mapped instruction cache with multi-beat line refill.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The transfer reads the
// tag and line memories into registers; the update tick that follows compares,
// writes any refill beat and loads the result registers, and busy is high
// during it. The result shows on the o_ result ports for exactly one cycle,
// flagged by o_done, in the cycle after the update; the receiver cannot stall
// it, so it must take the transfer in that cycle. A new request may be issued
// in that same cycle; no request is taken while busy is high.
// Line storage has no reset; a line word that was never written reads as
// garbage. Line and index sizes are powers of two.
// ----------------------------------------------------------------------------
module direct_mapped_icache_refill_top
    import dmicr_pkg::*;
#(
    parameter int NUM_LINES  = 32,
    parameter int LINE_BYTES = 16,
    parameter int BEAT_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    input  logic              i_req_valid,
    input  logic [ADDR_W-1:0] i_fetch_addr,
    input  logic              i_beat_valid,
    input  logic [DATA_W-1:0] i_beat_data,
    output logic              o_line_valid,
    output logic [HALF_W-1:0] o_line_low,
    output logic [HALF_W-1:0] o_line_high,
    output logic              o_miss_req,
    output logic [ADDR_W-1:0] o_miss_addr
);

    localparam int NUM_BEATS = LINE_BYTES / BEAT_BYTES;

    t_cmd cmd;
    t_sts sts;

    // sequencing and refill control
    dmicr_ctrl #(
        .NUM_BEATS (NUM_BEATS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // storage, compare and result registers
    dmicr_dpath #(
        .NUM_LINES  (NUM_LINES),
        .LINE_BYTES (LINE_BYTES),
        .BEAT_BYTES (BEAT_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_valid  (i_req_valid),
        .i_fetch_addr (i_fetch_addr),
        .i_beat_valid (i_beat_valid),
        .i_beat_data  (i_beat_data),
        .o_line_valid (o_line_valid),
        .o_line_low   (o_line_low),
        .o_line_high  (o_line_high),
        .o_miss_req   (o_miss_req),
        .o_miss_addr  (o_miss_addr)
    );

endmodule

>>> hdl/dmicr_dpath.sv
// ----------------------------------------------------------------------------
// Instruction cache refill - datapath
// Request registers, line/tag memories, valid bits, hit compare, result regs.
// ----------------------------------------------------------------------------
module dmicr_dpath
    import dmicr_pkg::*;
#(
    parameter int NUM_LINES  = 32,
    parameter int LINE_BYTES = 16,
    parameter int BEAT_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_req_valid,
    input  logic [ADDR_W-1:0] i_fetch_addr,
    input  logic              i_beat_valid,
    input  logic [DATA_W-1:0] i_beat_data,
    output logic              o_line_valid,
    output logic [HALF_W-1:0] o_line_low,
    output logic [HALF_W-1:0] o_line_high,
    output logic              o_miss_req,
    output logic [ADDR_W-1:0] o_miss_addr
);

    localparam int NUM_BEATS = LINE_BYTES / BEAT_BYTES;
    localparam int BEAT_W    = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;
    localparam int IDX_W     = $clog2(NUM_LINES);
    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int SHIFT     = OFF_W + IDX_W;
    localparam int BEAT_DW   = BEAT_BYTES * 8;
    localparam int LINE_DW   = LINE_BYTES * 8;

    logic              r_req;
    logic              r_bvalid;
    logic [DATA_W-1:0] r_bdata;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [TAG_W-1:0]  r_tag;

    logic [IDX_W-1:0]  in_idx;
    logic [ADDR_W-1:0] in_shift;
    logic [BEAT_W-1:0] beat_sel;
    logic [BEAT_DW+DATA_W-1:0] beat_ext;
    logic [BEAT_DW-1:0]        wr_data;
    logic [LINE_DW-1:0]        line_q;
    logic [LINE_DW+OUT_W-1:0]  line_pad;
    logic [OUT_W-1:0]          line_out;

    logic [TAG_W-1:0]  r_tag_mem [NUM_LINES];
    logic [TAG_W-1:0]  r_tag_q;
    logic [NUM_LINES-1:0] r_vbits;

    logic hit;
    logic miss;

    // split the incoming address
    assign in_idx   = i_fetch_addr[OFF_W +: IDX_W];
    assign in_shift = i_fetch_addr >> SHIFT;

    // latch the request on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_valid;
            r_bvalid <= i_beat_valid;
            r_bdata  <= i_beat_data;
            r_addr   <= i_fetch_addr;
            r_idx    <= in_idx;
            r_tag    <= in_shift[TAG_W-1:0];
        end
    end

    // beat payload: bytes past the bus width are zero
    assign beat_ext = {{BEAT_DW{1'b0}}, r_bdata};
    assign wr_data  = beat_ext[BEAT_DW-1:0];
    assign beat_sel = i_cmd.beat[BEAT_W-1:0];

    // one memory bank per beat slot, read at transfer, written on the update tick
    for (genvar b = 0; b < NUM_BEATS; b++) begin : g_bank
        logic [BEAT_DW-1:0] r_mem [NUM_LINES];
        logic [BEAT_DW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_en && (beat_sel == BEAT_W'(b))) begin
                r_mem[r_idx] <= wr_data;
            end
            if (i_cmd.capture) begin
                r_rd <= r_mem[in_idx];
            end
        end

        assign line_q[b*BEAT_DW +: BEAT_DW] = r_rd;
    end

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_valid) begin
            r_tag_mem[r_idx] <= r_tag;
        end
        if (i_cmd.capture) begin
            r_tag_q <= r_tag_mem[in_idx];
        end
    end

    // valid bits; the last beat wins over the first when both coincide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (i_cmd.set_valid) begin
            r_vbits[r_idx] <= 1'b1;
        end else if (i_cmd.clr_valid) begin
            r_vbits[r_idx] <= 1'b0;
        end
    end

    // compare against the state before this tick
    assign hit  = r_vbits[r_idx] && (r_tag_q == r_tag);
    assign miss = r_req && !hit;

    assign o_sts.req        = r_req;
    assign o_sts.beat_valid = r_bvalid;
    assign o_sts.hit        = hit;

    // window of the first sixteen line bytes, zero beyond the line
    assign line_pad = {{OUT_W{1'b0}}, line_q};
    assign line_out = line_pad[OUT_W-1:0];

    // load the result registers on the update tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_line_valid <= r_req && hit;
            o_line_low   <= (r_req && hit) ? line_out[HALF_W-1:0] : '0;
            o_line_high  <= (r_req && hit) ? line_out[OUT_W-1:HALF_W] : '0;
            o_miss_req   <= miss;
            o_miss_addr  <= miss ? r_addr : '0;
        end
    end

endmodule

>>> hdl/dmicr_ctrl.sv
// ----------------------------------------------------------------------------
// Instruction cache refill - controller
// Request sequencing and the refill beat machine.
// ----------------------------------------------------------------------------
`include "direct_mapped_icache_refill_top_macros.svh"

module dmicr_ctrl
    import dmicr_pkg::*;
#(
    parameter int NUM_BEATS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_done,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam int BEAT_W = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;
    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(NUM_BEATS - 1);

    // request sequencing states
    localparam logic S_READY = 1'b0;
    localparam logic S_EXEC  = 1'b1;
    // refill states
    localparam logic R_IDLE  = 1'b0;
    localparam logic R_BEAT  = 1'b1;

    logic              r_state, n_state;
    logic              r_refill, n_refill;
    logic [BEAT_W-1:0] r_beat, n_beat;
    logic              r_done;

    logic exec;
    logic active;
    logic miss;

    assign exec   = (r_state == S_EXEC);
    assign miss   = i_sts.req && !i_sts.hit;
    assign active = exec && (r_refill == R_BEAT) && i_sts.req && i_sts.beat_valid;

    assign o_busy = exec;
    assign o_done = r_done;

    // datapath commands
    assign o_cmd.capture   = i_start && (r_state == S_READY);
    assign o_cmd.exec      = exec;
    assign o_cmd.wr_en     = active;
    assign o_cmd.beat      = MAX_BEAT_W'(r_beat);
    assign o_cmd.clr_valid = active && (r_beat == '0);
    assign o_cmd.set_valid = active && (r_beat == LAST_BEAT);

    // sequence one update tick after each transfer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_READY: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_READY;
            default: n_state = S_READY;
        endcase
    end

    // advance the refill beat on update ticks
    always_comb begin
        n_refill = r_refill;
        n_beat   = r_beat;
        if (exec) begin
            unique case (r_refill)
                R_IDLE: begin
                    if (miss) begin
                        n_refill = R_BEAT;
                        n_beat   = '0;
                    end
                end
                R_BEAT: begin
                    if (i_sts.beat_valid) begin
                        if (r_beat == LAST_BEAT) begin
                            n_refill = R_IDLE;
                            n_beat   = '0;
                        end else begin
                            n_beat = r_beat + 1'b1;
                        end
                    end
                end
                default: n_refill = R_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_READY;
            r_refill <= R_IDLE;
            r_beat   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_refill <= n_refill;
            r_beat   <= n_beat;
            r_done   <= exec;
        end
    end

    `DMIC_ASSERT_NEXT(a_transfer_exec, i_clk, i_rst_n, i_start && !o_busy, o_cmd.exec)
    `DMIC_ASSERT_NEXT(a_exec_single, i_clk, i_rst_n, exec, !exec)
    `DMIC_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, exec, o_done)
    `DMIC_ASSERT_NEXT(a_beat_hold, i_clk, i_rst_n, !exec, $stable(r_beat) && $stable(r_refill))

endmodule

>>> tb/direct_mapped_icache_refill_top_tb.sv
// ----------------------------------------------------------------------------
// Instruction cache refill - testbench
// Drives fetch lookups and refill beats through the start/busy handshake and
// checks every o_done transfer against a cycle-free model of the cache lines,
// tags, valid bits and the refill beat sequencer.
// ----------------------------------------------------------------------------
module direct_mapped_icache_refill_top_tb;
    import dmicr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LINES   = 32;
    localparam int NUM_BEATS   = 4;
    localparam int OFF_W       = 4;
    localparam int IDX_W       = 5;
    localparam int STALL_LIMIT = 500;
    localparam int MAX_REPORTS = 10;
    localparam logic [ADDR_W-1:0] TAG_FLIP = 25'h100_0000;

    typedef enum logic [2:0] {
        REFILL_IDLE,
        REFILL_BEAT0,
        REFILL_BEAT1,
        REFILL_BEAT2,
        REFILL_BEAT3
    } t_refill_phase;

    typedef struct packed {
        logic              line_valid;
        logic [HALF_W-1:0] line_low;
        logic [HALF_W-1:0] line_high;
        logic              miss_req;
        logic [ADDR_W-1:0] miss_addr;
    } t_line_result;

    // ------------------------------------------------------------------------
    // Line store model and queue of expected lookup results
    // ------------------------------------------------------------------------
    class icache_scoreboard;
        bit                 line_ok[NUM_LINES];
        bit [TAG_W-1:0]     line_tag[NUM_LINES];
        bit [DATA_W-1:0]    line_word[NUM_LINES][NUM_BEATS];
        bit                 word_seen[NUM_LINES][NUM_BEATS];
        t_refill_phase      phase;
        t_line_result       lookup_q[$];
        int                 errors;
        int                 reports;
        int                 hits;
        int                 misses;
        int                 refills;

        function new();
            phase = REFILL_IDLE;
        endfunction

        function bit hits_line(logic [ADDR_W-1:0] addr);
            int idx;
            idx = addr[OFF_W +: IDX_W];
            return line_ok[idx] && (line_tag[idx] == addr[OFF_W+IDX_W +: TAG_W]);
        endfunction

        // a hit on a line that holds a never-written word must not be issued
        function bit reads_unwritten(logic [ADDR_W-1:0] addr);
            int idx;
            bit gap;
            idx = addr[OFF_W +: IDX_W];
            gap = 1'b0;
            for (int w = 0; w < NUM_BEATS; w++) gap |= !word_seen[idx][w];
            return hits_line(addr) && gap;
        endfunction

        function bit refill_busy();
            return phase != REFILL_IDLE;
        endfunction

        function int pending();
            return lookup_q.size();
        endfunction

        // note an accepted fetch transfer: predict its result, then update lines
        function void note_fetch(bit req, logic [ADDR_W-1:0] addr, bit bv,
                                 logic [DATA_W-1:0] data);
            t_line_result exp;
            int idx;
            int beat;
            bit hit;
            bit miss;
            idx  = addr[OFF_W +: IDX_W];
            hit  = req && hits_line(addr);
            miss = req && !hits_line(addr);
            exp.line_valid = hit;
            exp.line_low   = hit ? {line_word[idx][1], line_word[idx][0]} : '0;
            exp.line_high  = hit ? {line_word[idx][3], line_word[idx][2]} : '0;
            exp.miss_req   = miss;
            exp.miss_addr  = miss ? addr : '0;
            lookup_q.push_back(exp);
            hits   += hit;
            misses += miss;

            // write the beat only while the request is valid too
            if (phase != REFILL_IDLE && bv && req) begin
                beat = int'(phase) - int'(REFILL_BEAT0);
                line_word[idx][beat] = data;
                word_seen[idx][beat] = 1'b1;
                if (phase == REFILL_BEAT0) line_ok[idx] = 1'b0;
                if (phase == REFILL_BEAT3) begin
                    line_tag[idx] = addr[OFF_W+IDX_W +: TAG_W];
                    line_ok[idx]  = 1'b1;
                    refills++;
                end
            end

            // advance the beat sequencer
            if (phase == REFILL_IDLE) begin
                if (miss) phase = REFILL_BEAT0;
            end else if (bv) begin
                phase = (phase == REFILL_BEAT3) ? REFILL_IDLE
                                                : t_refill_phase'(phase + 3'd1);
            end
        endfunction

        // compare one o_done transfer with the oldest prediction
        function void check_line(t_line_result got);
            t_line_result exp;
            bit bad;
            if (lookup_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display("%0t: result transfer with no fetch outstanding", $realtime);
                reports++;
                return;
            end
            exp = lookup_q.pop_front();
            bad = (got.line_valid !== exp.line_valid) || (got.line_low !== exp.line_low)
               || (got.line_high !== exp.line_high) || (got.miss_req !== exp.miss_req)
               || (got.miss_addr !== exp.miss_addr);
            if (bad) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t: exp hit=%b low=%h high=%h miss=%b addr=%h", $realtime,
                             exp.line_valid, exp.line_low, exp.line_high,
                             exp.miss_req, exp.miss_addr);
                    $display("%0t: got hit=%b low=%h high=%h miss=%b addr=%h", $realtime,
                             got.line_valid, got.line_low, got.line_high,
                             got.miss_req, got.miss_addr);
                end
                reports++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              o_done;
    logic              i_req_valid = 1'b0;
    logic [ADDR_W-1:0] i_fetch_addr = '0;
    logic              i_beat_valid = 1'b0;
    logic [DATA_W-1:0] i_beat_data = '0;
    logic              o_line_valid;
    logic [HALF_W-1:0] o_line_low;
    logic [HALF_W-1:0] o_line_high;
    logic              o_miss_req;
    logic [ADDR_W-1:0] o_miss_addr;

    icache_scoreboard  sb = new();
    t_line_result      got_line;
    int                idle_pct = 38;
    int                n_items;
    int                stall_cycles;
    logic [TAG_W-1:0]  tag_pool[4];
    logic [ADDR_W-1:0] filled_q[$];

    direct_mapped_icache_refill_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .o_done       (o_done),
        .i_req_valid  (i_req_valid),
        .i_fetch_addr (i_fetch_addr),
        .i_beat_valid (i_beat_valid),
        .i_beat_data  (i_beat_data),
        .o_line_valid (o_line_valid),
        .o_line_low   (o_line_low),
        .o_line_high  (o_line_high),
        .o_miss_req   (o_miss_req),
        .o_miss_addr  (o_miss_addr)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got_line = {o_line_valid, o_line_low, o_line_high, o_miss_req, o_miss_addr};
            sb.check_line(got_line);
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one fetch, hold it until taken, then sometimes drop start and idle
    task automatic send_fetch(input bit req, input logic [ADDR_W-1:0] addr,
                              input bit bv, input logic [DATA_W-1:0] data);
        if (req && sb.reads_unwritten(addr)) addr ^= TAG_FLIP;
        start        <= 1'b1;
        i_req_valid  <= req;
        i_fetch_addr <= addr;
        i_beat_valid <= bv;
        i_beat_data  <= data;
        do @(posedge i_clk); while (busy);
        sb.note_fetch(req, addr, bv, data);
        n_items++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every lookup has reported
    task automatic drain_lookups();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(9) == 0) return ADDR_W'($urandom);
        return {tag_pool[$urandom_range(3)], IDX_W'($urandom), OFF_W'($urandom)};
    endfunction

    // miss on a line, then deliver its four beats with stalls in between
    task automatic run_refill();
        logic [ADDR_W-1:0] addr;
        bit broken;
        bit skip;
        int k;
        addr   = pick_addr();
        broken = 1'b0;
        k      = 0;
        if (sb.hits_line(addr)) addr ^= TAG_FLIP;
        while (sb.refill_busy()) send_fetch(1'b0, ADDR_W'($urandom), 1'b1, $urandom);
        send_fetch(1'b1, addr, 1'($urandom_range(1)), $urandom);
        while (k < NUM_BEATS) begin
            if ($urandom_range(4) == 0) begin
                send_fetch(1'($urandom_range(1)), addr, 1'b0, $urandom);
            end else begin
                skip = ($urandom_range(9) == 0);
                broken |= skip;
                send_fetch(!skip, {addr[ADDR_W-1:OFF_W], OFF_W'($urandom)}, 1'b1, $urandom);
                k++;
            end
        end
        if (!broken) begin
            filled_q.push_back(addr);
            if (filled_q.size() > 24) void'(filled_q.pop_front());
        end
    endtask

    // read back lines that were filled earlier
    task automatic run_reads();
        logic [ADDR_W-1:0] addr;
        repeat ($urandom_range(4, 1)) begin
            addr = filled_q[$urandom_range(filled_q.size() - 1)];
            send_fetch(1'b1, {addr[ADDR_W-1:OFF_W], OFF_W'($urandom)},
                       $urandom_range(3) == 0, $urandom);
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
                run_refill();
            end else if (pick < 8 && filled_q.size() != 0) begin
                run_reads();
            end else begin
                repeat ($urandom_range(3, 1))
                    send_fetch(1'($urandom_range(1)), ADDR_W'($urandom),
                               1'($urandom_range(1)), $urandom);
            end
        end
    endtask

    initial begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'($urandom);
        tag_pool[3] = TAG_W'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no request, beat while idle, then a full refill at the top address
        send_fetch(1'b0, 25'h1FF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fetch(1'b1, 25'h1FF_FFFF, 1'b0, 32'h0);
        send_fetch(1'b1, 25'h1FF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fetch(1'b1, 25'h1FF_FFF3, 1'b1, 32'h0000_0000);
        send_fetch(1'b1, 25'h1FF_FFF8, 1'b1, 32'hA5A5_A5A5);
        send_fetch(1'b1, 25'h1FF_FFFC, 1'b1, 32'h5A5A_5A5A);
        send_fetch(1'b1, 25'h1FF_FFF0, 1'b0, 32'h0);
        // refill line 0 with a beat stall, then hit it
        send_fetch(1'b1, 25'h000_0000, 1'b0, 32'h0);
        send_fetch(1'b1, 25'h000_0000, 1'b1, 32'h0302_0100);
        send_fetch(1'b1, 25'h000_0004, 1'b0, 32'hDEAD_BEEF);
        send_fetch(1'b1, 25'h000_0008, 1'b1, 32'h0706_0504);
        send_fetch(1'b1, 25'h000_0000, 1'b1, 32'h0B0A_0908);
        send_fetch(1'b1, 25'h000_000F, 1'b1, 32'h0F0E_0D0C);
        send_fetch(1'b1, 25'h000_0000, 1'b0, 32'h0);
        // evict line 0; one beat arrives without a request and is dropped
        send_fetch(1'b1, 25'h000_0200, 1'b1, 32'h0);
        send_fetch(1'b1, 25'h000_0200, 1'b1, 32'h1111_1111);
        send_fetch(1'b0, 25'h000_0200, 1'b1, 32'h2222_2222);
        send_fetch(1'b1, 25'h000_0200, 1'b1, 32'h3333_3333);
        send_fetch(1'b1, 25'h000_0200, 1'b1, 32'h4444_4444);
        send_fetch(1'b1, 25'h000_0200, 1'b0, 32'h0);
        // move the fetch address to another line in the middle of a refill
        send_fetch(1'b1, 25'h000_0030, 1'b0, 32'h0);
        send_fetch(1'b1, 25'h000_0030, 1'b1, 32'h1234_5678);
        send_fetch(1'b1, 25'h000_0040, 1'b1, 32'h9ABC_DEF0);
        send_fetch(1'b1, 25'h000_0044, 1'b1, 32'h0F1E_2D3C);
        send_fetch(1'b1, 25'h000_0048, 1'b1, 32'h4B5A_6978);

        run_random(150);
        drain_lookups();
        idle_pct = 65;
        run_random(150);
        idle_pct = 0;
        run_random(150);
        drain_lookups();
        repeat (8) @(posedge i_clk);

        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0d lookups never reported", sb.pending());
        end
        $display("covered %0d fetches: %0d hits, %0d misses, %0d complete line refills",
                 n_items, sb.hits, sb.misses, sb.refills);
        $display("sender idle mix 38/65/0 percent with a full drain; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
